FILE: rtl/rotation_to_roll_pitch_yaw_macros.svh
// assertion macros for the roll, pitch and yaw block
`ifndef ROTATION_TO_ROLL_PITCH_YAW_MACROS_SVH
`define ROTATION_TO_ROLL_PITCH_YAW_MACROS_SVH

// same-cycle implication, switched off during reset
`define RPY_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, switched off during reset
`define RPY_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rpy_pkg.sv
// shared constants, types and arctangent table for the roll, pitch and yaw block
package rpy_pkg;

    localparam int INPUT_W         = 16;
    localparam int GUARD_BITS      = 16;
    localparam int MARGIN_W        = 11;
    localparam int ROOT_W          = 32;
    localparam int SUMSQ_W         = 32;
    localparam int SQ_W            = 31;
    localparam int REM_W           = 35;
    localparam int DATA_W          = 36;
    localparam int ACC_W           = 35;
    localparam int ACC_FRAC        = 30;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STAGES   = 16;
    localparam int SQRT_STAGES     = ROOT_W;
    localparam int ROLL_W          = 16;
    localparam int PITCH_W         = 15;
    localparam int SHIFT_OUT       = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int ANG_W           = ACC_W - SHIFT_OUT + 1;

    // operands wait for the squares, the sum and the root
    localparam int OPND_DELAY = 2 + SQRT_STAGES;
    localparam int PIPE_LAT   = OPND_DELAY + 1 + CORDIC_STAGES + 1;

    localparam logic signed [ACC_W-1:0] PI_ACC      = 35'sd3373259426;
    localparam logic signed [ACC_W-1:0] HALF_PI_ACC = 35'sd1686629713;
    localparam logic signed [ACC_W-1:0] ROUND_HALF  = ACC_W'(64'sd1 <<< (SHIFT_OUT - 1));

    localparam logic signed [ANG_W-1:0] PI_Q =
        ANG_W'((PI_ACC + ROUND_HALF) >>> SHIFT_OUT);
    localparam logic signed [ANG_W-1:0] HALF_PI_Q =
        ANG_W'((HALF_PI_ACC + ROUND_HALF) >>> SHIFT_OUT);

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(8);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        logic signed [INPUT_W-1:0] m20;
        logic signed [INPUT_W-1:0] m21;
        logic signed [INPUT_W-1:0] m22;
        logic signed [INPUT_W-1:0] m10;
        logic signed [INPUT_W-1:0] m00;
    } t_mat;

    // atan(2^-i) scaled by 2^30, truncated, but entries 27 to 30 rounded
    function automatic t_acc atan_entry(input logic [4:0] idx);
        t_acc v;
        unique case (idx)
            5'd0:  v = 35'sh03243F6A8;
            5'd1:  v = 35'sh01DAC6705;
            5'd2:  v = 35'sh00FADBAFC;
            5'd3:  v = 35'sh007F56EA6;
            5'd4:  v = 35'sh003FEAB76;
            5'd5:  v = 35'sh001FFD55B;
            5'd6:  v = 35'sh000FFFAAA;
            5'd7:  v = 35'sh0007FFF55;
            5'd8:  v = 35'sh0003FFFEA;
            5'd9:  v = 35'sh0001FFFFD;
            5'd10: v = 35'sh0000FFFFF;
            5'd11: v = 35'sh00007FFFF;
            5'd12: v = 35'sh00003FFFF;
            5'd13: v = 35'sh00001FFFF;
            5'd14: v = 35'sh00000FFFF;
            5'd15: v = 35'sh000007FFF;
            5'd16: v = 35'sh000003FFF;
            5'd17: v = 35'sh000001FFF;
            5'd18: v = 35'sh000000FFF;
            5'd19: v = 35'sh0000007FF;
            5'd20: v = 35'sh0000003FF;
            5'd21: v = 35'sh0000001FF;
            5'd22: v = 35'sh0000000FF;
            5'd23: v = 35'sh00000007F;
            5'd24: v = 35'sh00000003F;
            5'd25: v = 35'sh00000001F;
            5'd26: v = 35'sh00000000F;
            5'd27: v = 35'sh000000008;
            5'd28: v = 35'sh000000004;
            5'd29: v = 35'sh000000002;
            5'd30: v = 35'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/rpy_channels.sv
// valid/ready channel interfaces for matrix entries in and angles out
interface rpy_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rpy_pkg::INPUT_W-1:0]   m20;
    logic signed [rpy_pkg::INPUT_W-1:0]   m21;
    logic signed [rpy_pkg::INPUT_W-1:0]   m22;
    logic signed [rpy_pkg::INPUT_W-1:0]   m10;
    logic signed [rpy_pkg::INPUT_W-1:0]   m00;

    modport source (output valid, m20, m21, m22, m10, m00, input ready);
    modport sink   (input valid, m20, m21, m22, m10, m00, output ready);
endinterface

interface rpy_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rpy_pkg::ROLL_W-1:0]    roll_angle;
    logic signed [rpy_pkg::PITCH_W-1:0]   pitch_angle;
    logic signed [rpy_pkg::ROLL_W-1:0]    yaw_angle;
    logic                                 singular;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, singular, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, singular, output ready);
endinterface

FILE: rtl/rpy_isqrt.sv
// pipelined floor square root of a sum of squares scaled by 2^32, one root bit per stage
module rpy_isqrt (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  logic [rpy_pkg::SUMSQ_W-1:0] i_sumsq,
    output logic [rpy_pkg::ROOT_W-1:0]  o_root
);
    import rpy_pkg::*;

    logic [REM_W-1:0]   r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0]  r_root [SQRT_STAGES];
    logic [SUMSQ_W-1:0] r_src  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [REM_W-1:0]   p_rem;
        logic [ROOT_W-1:0]  p_root;
        logic [SUMSQ_W-1:0] p_src;
        logic [REM_W-1:0]   rem_sh;
        logic [REM_W-1:0]   trial;
        logic               take;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_src  = i_sumsq;
        end else begin : g_rest
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_src  = r_src[k-1];
        end

        // low half of the scaled operand is all zero, so zeros shift in
        assign rem_sh = {p_rem[REM_W-3:0], p_src[SUMSQ_W-1:SUMSQ_W-2]};
        assign trial  = REM_W'({p_root, 2'b01});
        assign take   = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k]  <= take ? (rem_sh - trial) : rem_sh;
                r_root[k] <= {p_root[ROOT_W-2:0], take};
                r_src[k]  <= {p_src[SUMSQ_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

FILE: rtl/rpy_cordic.sv
// pipelined vectoring cordic giving atan2(y, x) with 30 fraction bits
module rpy_cordic (
    input  logic                 i_clk,
    input  logic                 i_ce,
    input  rpy_pkg::t_data       i_y,
    input  rpy_pkg::t_data       i_x,
    output rpy_pkg::t_acc        o_z
);
    import rpy_pkg::*;

    t_data r_x    [CORDIC_STAGES+1];
    t_data r_y    [CORDIC_STAGES+1];
    t_acc  r_z    [CORDIC_STAGES+1];
    logic  r_zero [CORDIC_STAGES+1];

    // quadrant fold: left half-plane is rotated by pi
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y >= 0) ? PI_ACC : -PI_ACC;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        t_data xs;
        t_data ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + atan_entry(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - atan_entry(5'(i));
                end
            end
        end
    end

    assign o_z = r_zero[CORDIC_STAGES] ? '0 : r_z[CORDIC_STAGES];

endmodule

FILE: rtl/rotation_to_roll_pitch_yaw.sv
// rotation matrix to roll, pitch and yaw: top level
//
// i_in carries five Q1.14 matrix entries (m20, m21, m22, m10, m00); a transaction
// happens when valid and ready are both high. o_out carries roll, pitch and yaw
// in Q2.13 radians (pitch in Q1.13) and a singular flag for pitch near +-pi/2.
// i_cfg_we/i_cfg_wdata write the singularity margin; write only while idle.
// Throughput: one matrix per cycle while o_out is not stalled. The pipe runs
// through squaring and summing stages, the 32-stage square root (one root bit
// per stage), the fold and the three 16-stage cordic units, and an output stage.
// All stages share one clock enable: when o_out holds a result that is not
// taken, the whole pipe stops and i_in.ready drops, nothing is lost or repeated.
// Bubbles move forward while the output is empty or being taken.
// Reset (synchronous, active low) empties the pipe and sets the margin to 8.
// Results leave in input order, one per accepted matrix.
module rotation_to_roll_pitch_yaw (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rpy_pkg::MARGIN_W-1:0]   i_cfg_wdata,
    rpy_in_if.sink                         i_in,
    rpy_out_if.source                      o_out
);
    import rpy_pkg::*;
    `include "rotation_to_roll_pitch_yaw_macros.svh"

    logic                  r_ce;
    logic [MARGIN_W-1:0]   r_margin;
    logic [PIPE_LAT-1:0]   r_vld;
    logic [SQ_W-1:0]       r_sq21;
    logic [SQ_W-1:0]       r_sq22;
    logic [SUMSQ_W-1:0]    r_sumsq;
    t_mat                  r_dly [OPND_DELAY];
    logic [ROOT_W-1:0]     root;
    t_acc                  z_pitch;
    t_acc                  z_roll;
    t_acc                  z_yaw;
    logic signed [ROLL_W-1:0]  r_roll;
    logic signed [PITCH_W-1:0] r_pitch;
    logic signed [ROLL_W-1:0]  r_yaw;
    logic                  r_sing;
    logic signed [2*INPUT_W-1:0] p21;
    logic signed [2*INPUT_W-1:0] p22;
    t_mat                  in_mat;
    t_mat                  d_mat;
    logic signed [ANG_W-1:0] a_roll;
    logic signed [ANG_W-1:0] a_pitch;
    logic signed [ANG_W-1:0] a_yaw;
    logic signed [ANG_W-1:0] c_roll;
    logic signed [ANG_W-1:0] c_pitch;
    logic signed [ANG_W-1:0] c_yaw;
    logic signed [ANG_W-1:0] abs_pitch;
    logic signed [ANG_W-1:0] gap;

    function automatic logic signed [ANG_W-1:0] round_angle(input t_acc z);
        t_acc s;
        s = (z + ROUND_HALF) >>> SHIFT_OUT;
        return s[ANG_W-1:0];
    endfunction

    function automatic logic signed [ANG_W-1:0] clamp_sym(
        input logic signed [ANG_W-1:0] v,
        input logic signed [ANG_W-1:0] lim
    );
        logic signed [ANG_W-1:0] r;
        priority if (v > lim)  r = lim;
        else if (v < -lim)     r = -lim;
        else                   r = v;
        return r;
    endfunction

    assign r_ce       = !o_out.valid || o_out.ready;
    // no transaction is taken while reset clears the pipe
    assign i_in.ready = r_ce && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_we) begin
            r_margin <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (r_ce) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in.valid};
        end
    end

    assign in_mat = '{m20: i_in.m20, m21: i_in.m21, m22: i_in.m22,
                      m10: i_in.m10, m00: i_in.m00};
    assign p21 = i_in.m21 * i_in.m21;
    assign p22 = i_in.m22 * i_in.m22;

    always_ff @(posedge i_clk) begin
        if (r_ce) begin
            r_sq21   <= p21[SQ_W-1:0];
            r_sq22   <= p22[SQ_W-1:0];
            r_sumsq  <= SUMSQ_W'(r_sq21) + SUMSQ_W'(r_sq22);
            r_dly[0] <= in_mat;
        end
    end

    for (genvar k = 1; k < OPND_DELAY; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (r_ce) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign d_mat = r_dly[OPND_DELAY-1];

    rpy_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_ce    (r_ce),
        .i_sumsq (r_sumsq),
        .o_root  (root)
    );

    rpy_cordic u_pitch (
        .i_clk (i_clk),
        .i_ce  (r_ce),
        .i_y   (-(t_data'(d_mat.m20) <<< GUARD_BITS)),
        .i_x   (t_data'({1'b0, root})),
        .o_z   (z_pitch)
    );

    rpy_cordic u_roll (
        .i_clk (i_clk),
        .i_ce  (r_ce),
        .i_y   (t_data'(d_mat.m21) <<< GUARD_BITS),
        .i_x   (t_data'(d_mat.m22) <<< GUARD_BITS),
        .o_z   (z_roll)
    );

    rpy_cordic u_yaw (
        .i_clk (i_clk),
        .i_ce  (r_ce),
        .i_y   (t_data'(d_mat.m10) <<< GUARD_BITS),
        .i_x   (t_data'(d_mat.m00) <<< GUARD_BITS),
        .o_z   (z_yaw)
    );

    always_comb begin
        a_roll    = round_angle(z_roll);
        a_pitch   = round_angle(z_pitch);
        a_yaw     = round_angle(z_yaw);
        c_roll    = clamp_sym(a_roll, PI_Q);
        c_pitch   = clamp_sym(a_pitch, HALF_PI_Q);
        c_yaw     = clamp_sym(a_yaw, PI_Q);
        abs_pitch = (c_pitch < 0) ? -c_pitch : c_pitch;
        gap       = HALF_PI_Q - abs_pitch;
    end

    always_ff @(posedge i_clk) begin
        if (r_ce) begin
            r_roll  <= c_roll[ROLL_W-1:0];
            r_pitch <= c_pitch[PITCH_W-1:0];
            r_yaw   <= c_yaw[ROLL_W-1:0];
            r_sing  <= (gap < $signed({1'b0, {(ANG_W-MARGIN_W-1){1'b0}}, r_margin}));
        end
    end

    assign o_out.valid       = r_vld[PIPE_LAT-1];
    assign o_out.roll_angle  = r_roll;
    assign o_out.pitch_angle = r_pitch;
    assign o_out.yaw_angle   = r_yaw;
    assign o_out.singular    = r_sing;

    `RPY_ASSERT_NOW(a_pitch_range, i_clk, i_rst_n, o_out.valid,
        (o_out.pitch_angle <= HALF_PI_Q) && (o_out.pitch_angle >= -HALF_PI_Q),
        "pitch outside half pi")
    `RPY_ASSERT_NOW(a_roll_range, i_clk, i_rst_n, o_out.valid,
        (o_out.roll_angle <= PI_Q) && (o_out.roll_angle >= -PI_Q),
        "roll outside pi")
    `RPY_ASSERT_NOW(a_no_sing_zero, i_clk, i_rst_n, o_out.valid && (r_margin == '0),
        !o_out.singular, "singular raised with zero margin")
    `RPY_ASSERT_NEXT(a_stall_freeze, i_clk, i_rst_n, !r_ce,
        $stable(r_vld), "pipe valid bits moved during stall")

endmodule

FILE: tb/sv/rotation_to_roll_pitch_yaw_tb.sv
// testbench for the rotation matrix to roll, pitch and yaw block
`timescale 1ns / 100ps

module rotation_to_roll_pitch_yaw_tb;
    import rpy_pkg::*;

    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ROLL_W-1:0]  yaw;
        logic                      sing;
    } t_angles;

    localparam longint ACC_PI   = 64'sd3373259426;
    localparam longint ACC_HPI  = 64'sd1686629713;
    localparam int     LAT      = 52;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [MARGIN_W-1:0] i_cfg_wdata = '0;

    rpy_in_if  in_ch();
    rpy_out_if out_ch();

    rotation_to_roll_pitch_yaw u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_mat        pending_mats[$];
    t_angles     expected_angles[$];
    logic [MARGIN_W-1:0] margin_model = MARGIN_RESET;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          n_singular = 0;

    // floor division by a power of two, valid for negatives too
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? ACC_PI : -ACC_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_entry(5'(i)));
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_entry(5'(i)));
            end
        end
        return z;
    endfunction

    function automatic longint quantise_clamp(longint z, longint lim);
        longint v;
        v = shr_floor(z + (64'sd1 <<< (SHIFT_OUT - 1)), SHIFT_OUT);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_angles euler_from_matrix(t_mat m, logic [MARGIN_W-1:0] margin);
        t_angles a;
        longint g, hyp, pi_q, hpi_q, p, r, yw, ap;
        longint unsigned sumsq;
        g = 64'sd1 <<< GUARD_BITS;
        pi_q = shr_floor(ACC_PI + (64'sd1 <<< (SHIFT_OUT - 1)), SHIFT_OUT);
        hpi_q = shr_floor(ACC_HPI + (64'sd1 <<< (SHIFT_OUT - 1)), SHIFT_OUT);
        sumsq = longint'(m.m21) * m.m21 + longint'(m.m22) * m.m22;
        hyp = root_floor(sumsq << (2 * GUARD_BITS));
        p = quantise_clamp(vector_angle(-longint'(m.m20) * g, hyp), hpi_q);
        r = quantise_clamp(vector_angle(longint'(m.m21) * g, longint'(m.m22) * g), pi_q);
        yw = quantise_clamp(vector_angle(longint'(m.m10) * g, longint'(m.m00) * g), pi_q);
        ap = p < 0 ? -p : p;
        a.roll = ROLL_W'(r);
        a.pitch = PITCH_W'(p);
        a.yaw = ROLL_W'(yw);
        a.sing = (hpi_q - ap) < longint'(margin);
        return a;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_mats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_mat m;
                    m = pending_mats.pop_front();
                    in_ch.valid <= 1'b1;
                    {in_ch.m20, in_ch.m21, in_ch.m22, in_ch.m10, in_ch.m00} <= m;
                    expected_angles = {expected_angles, euler_from_matrix(m, margin_model)};
                    n_sent++;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        {in_ch.m20, in_ch.m21, in_ch.m22, in_ch.m10, in_ch.m00} = '0;
        out_ch.ready = 1'b0;
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_angles.size() == 0) begin
                    $error("result with nothing expected");
                    n_errors++;
                end else begin
                    t_angles e;
                    e = expected_angles.pop_front();
                    n_checked++;
                    if (e.sing) n_singular++;
                    if (out_ch.roll_angle !== e.roll) begin
                        $error("roll_angle exp %0d got %0d", e.roll, out_ch.roll_angle);
                        n_errors++;
                    end
                    if (out_ch.pitch_angle !== e.pitch) begin
                        $error("pitch_angle exp %0d got %0d", e.pitch, out_ch.pitch_angle);
                        n_errors++;
                    end
                    if (out_ch.yaw_angle !== e.yaw) begin
                        $error("yaw_angle exp %0d got %0d", e.yaw, out_ch.yaw_angle);
                        n_errors++;
                    end
                    if (out_ch.singular !== e.sing) begin
                        $error("singular exp %0d got %0d", e.sing, out_ch.singular);
                        n_errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [INPUT_W-1:0] rand_entry();
        case ($urandom_range(9))
            0: return INPUT_W'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'sd0;
            4: return INPUT_W'($signed($urandom_range(16)) - 8);
            default: return INPUT_W'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic void add_matrix(t_mat m);
        pending_mats = {pending_mats, m};
    endfunction

    task automatic queue_random(int n);
        t_mat m;
        for (int i = 0; i < n; i++) begin
            m.m20 = rand_entry();
            m.m21 = rand_entry();
            m.m22 = rand_entry();
            m.m10 = rand_entry();
            m.m00 = rand_entry();
            // pitch close to the pole so the singular flag toggles
            if ($urandom_range(3) == 0) begin
                m.m21 = INPUT_W'($signed($urandom_range(40)) - 20);
                m.m22 = INPUT_W'($signed($urandom_range(40)) - 20);
            end
            add_matrix(m);
        end
    endtask

    task automatic drain_and_set(logic [MARGIN_W-1:0] margin);
        while (pending_mats.size() > 0 || expected_angles.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= margin;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        margin_model = margin;
    endtask

    task automatic queue_directed();
        add_matrix({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        add_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384});
        add_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0});
        add_matrix({16'sd0, 16'sd0, -16'sd16384, 16'sd0, -16'sd16384});
        add_matrix({16'sd0, 16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384});
        add_matrix({16'sd0, -16'sd16384, 16'sd0, -16'sd16384, -16'sd16384});
        add_matrix({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        add_matrix({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        add_matrix({16'sd16384, 16'sd3, -16'sd2, 16'sd1, -16'sd1});
        add_matrix({-16'sd16384, -16'sd5, 16'sd1, -16'sd1, 16'sd1});
        add_matrix({16'sd11585, 16'sd0, 16'sd11585, 16'sd11585, 16'sd11585});
        add_matrix({-16'sd1, 16'sd16384, -16'sd16384, 16'sd1, -16'sd16384});
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        queue_directed();
        queue_random(300);
        drain_and_set(11'd0);
        queue_directed();
        send_idle_pct = 84;
        queue_random(350);
        drain_and_set(11'd1024);
        recv_stall_pct = 84;
        send_idle_pct = 0;
        queue_random(350);
        drain_and_set(11'd2047);
        send_idle_pct = 10;
        recv_stall_pct = 10;
        queue_random(350);
        drain_and_set(11'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(200);
        drain_and_set(11'($urandom_range(1024)));
        send_idle_pct = 50;
        recv_stall_pct = 50;
        queue_random(200);
        while (pending_mats.size() > 0 || expected_angles.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        $display("sent %0d matrices, checked %0d results (%0d singular) over six margins",
                 n_sent, n_checked, n_singular);
        if (n_errors == 0 && expected_angles.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rpy_pkg.sv
rtl/rpy_channels.sv
rtl/rpy_isqrt.sv
rtl/rpy_cordic.sv
rtl/rotation_to_roll_pitch_yaw.sv
tb/sv/rotation_to_roll_pitch_yaw_tb.sv
